[rtl/aabb_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the box collide and resolve pipeline.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_W = 32;
    localparam int HALF_W  = 30;
    localparam int DIFF_W  = COORD_W + 1;   // center difference
    localparam int SUM_W   = HALF_W + 1;    // half-extent sum
    localparam int OV_W    = DIFF_W + 1;    // signed overlap
    localparam int PUSH_W  = OV_W + 1;      // signed push before saturation
    localparam int NUM_AX  = 3;

    localparam logic signed [COORD_W-1:0] PUSH_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] PUSH_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // per-axis overlap result handed to the axis select stage
    typedef struct packed {
        logic signed [OV_W-1:0] ov;
        logic                   dl_pos;
    } t_axis_res;

endpackage

[rtl/aabb_axis.sv]
// ----------------------------------------------------------------------------
// aabb_axis
// Two-stage per-axis unit: center difference and half sum, then signed
// overlap (half sum minus absolute difference).
// ----------------------------------------------------------------------------
module aabb_axis
    import aabb_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_ca,
    input  logic        [HALF_W-1:0]  i_ha,
    input  logic signed [COORD_W-1:0] i_cb,
    input  logic        [HALF_W-1:0]  i_hb,
    output t_axis_res                 o_res
);

    logic signed [DIFF_W-1:0] r_dl, n_dl;
    logic        [SUM_W-1:0]  r_hs, n_hs;
    t_axis_res                r_res, n_res;
    logic        [DIFF_W-1:0] abs_dl;

    always_comb begin
        n_dl = {i_cb[COORD_W-1], i_cb} - {i_ca[COORD_W-1], i_ca};
        n_hs = {1'b0, i_ha} + {1'b0, i_hb};
    end

    always_comb begin
        abs_dl       = r_dl[DIFF_W-1] ? DIFF_W'(-r_dl) : DIFF_W'(r_dl);
        n_res.ov     = $signed({{(OV_W-SUM_W){1'b0}}, r_hs}) - $signed({1'b0, abs_dl});
        n_res.dl_pos = !r_dl[DIFF_W-1] && (r_dl != '0);
    end

    always_ff @(posedge i_clk) begin
        r_dl  <= n_dl;
        r_hs  <= n_hs;
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

[rtl/aabb_select.sv]
// ----------------------------------------------------------------------------
// aabb_select
// Two-stage resolve: hit test and least-penetration axis pick (ties to x,
// then y), then signed push with saturation.
// ----------------------------------------------------------------------------
module aabb_select
    import aabb_pkg::*;
(
    input  logic                      i_clk,
    input  t_axis_res                 i_res [NUM_AX],
    output logic                      o_hit,
    output logic signed [COORD_W-1:0] o_push [NUM_AX]
);

    logic                     r_hit, n_hit;
    logic [NUM_AX-1:0]        r_sel, n_sel;
    logic signed [OV_W-1:0]   r_ov, n_ov;
    logic                     r_pos, n_pos;
    logic                     r_hit2;
    logic signed [COORD_W-1:0] r_push [NUM_AX];
    logic signed [COORD_W-1:0] n_push [NUM_AX];
    logic signed [PUSH_W-1:0]  sp;
    logic signed [COORD_W-1:0] sat;

    always_comb begin
        n_hit = !i_res[0].ov[OV_W-1] && !i_res[1].ov[OV_W-1] && !i_res[2].ov[OV_W-1];
        if (i_res[0].ov <= i_res[1].ov && i_res[0].ov <= i_res[2].ov) begin
            n_sel = 3'b001;
        end else if (i_res[1].ov <= i_res[2].ov) begin
            n_sel = 3'b010;
        end else begin
            n_sel = 3'b100;
        end
        n_ov  = n_sel[0] ? i_res[0].ov : (n_sel[1] ? i_res[1].ov : i_res[2].ov);
        n_pos = n_sel[0] ? i_res[0].dl_pos
              : (n_sel[1] ? i_res[1].dl_pos : i_res[2].dl_pos);
    end

    always_comb begin
        sp = r_pos ? -PUSH_W'(r_ov) : PUSH_W'(r_ov);
        if (sp > PUSH_W'(PUSH_MAX)) begin
            sat = PUSH_MAX;
        end else if (sp < PUSH_W'(PUSH_MIN)) begin
            sat = PUSH_MIN;
        end else begin
            sat = sp[COORD_W-1:0];
        end
        for (int k = 0; k < NUM_AX; k++) begin
            n_push[k] = (r_hit && r_sel[k]) ? sat : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_sel  <= n_sel;
        r_ov   <= n_ov;
        r_pos  <= n_pos;
        r_hit2 <= r_hit;
        r_push <= n_push;
    end

    assign o_hit  = r_hit2;
    assign o_push = r_push;

endmodule

[rtl/aabb_collide_resolve_unit.sv]
// ----------------------------------------------------------------------------
// aabb_collide_resolve_unit
// Box pair overlap test with least-penetration push-out for box A.
// ----------------------------------------------------------------------------
// Takes one box pair per clock (busy is never raised) and returns each result
// marked by o_valid for one cycle, after four register stages: center
// difference and half sum, overlap, axis pick, push and saturation. Results
// cannot be held off; the receiver must take each one in the cycle it appears.
module aabb_collide_resolve_unit
    import aabb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_a_center_x,
    input  logic signed [COORD_W-1:0] i_a_center_y,
    input  logic signed [COORD_W-1:0] i_a_center_z,
    input  logic        [HALF_W-1:0]  i_a_half_x,
    input  logic        [HALF_W-1:0]  i_a_half_y,
    input  logic        [HALF_W-1:0]  i_a_half_z,
    input  logic signed [COORD_W-1:0] i_b_center_x,
    input  logic signed [COORD_W-1:0] i_b_center_y,
    input  logic signed [COORD_W-1:0] i_b_center_z,
    input  logic        [HALF_W-1:0]  i_b_half_x,
    input  logic        [HALF_W-1:0]  i_b_half_y,
    input  logic        [HALF_W-1:0]  i_b_half_z,
    output logic                      o_valid,
    output logic                      o_collided,
    output logic signed [COORD_W-1:0] o_push_x,
    output logic signed [COORD_W-1:0] o_push_y,
    output logic signed [COORD_W-1:0] o_push_z,
    output logic                      o_stop_motion
);

    localparam int LAT = 4;

    logic signed [COORD_W-1:0] ca [NUM_AX];
    logic signed [COORD_W-1:0] cb [NUM_AX];
    logic        [HALF_W-1:0]  ha [NUM_AX];
    logic        [HALF_W-1:0]  hb [NUM_AX];
    t_axis_res                 res [NUM_AX];
    logic signed [COORD_W-1:0] push [NUM_AX];
    logic                      hit;
    logic [LAT-1:0]            r_vld, n_vld;

    assign ca = '{i_a_center_x, i_a_center_y, i_a_center_z};
    assign cb = '{i_b_center_x, i_b_center_y, i_b_center_z};
    assign ha = '{i_a_half_x, i_a_half_y, i_a_half_z};
    assign hb = '{i_b_half_x, i_b_half_y, i_b_half_z};

    genvar g;
    generate
        for (g = 0; g < NUM_AX; g++) begin : g_axis
            aabb_axis u_axis (
                .i_clk (i_clk),
                .i_ca  (ca[g]),
                .i_ha  (ha[g]),
                .i_cb  (cb[g]),
                .i_hb  (hb[g]),
                .o_res (res[g])
            );
        end
    endgenerate

    aabb_select u_select (
        .i_clk  (i_clk),
        .i_res  (res),
        .o_hit  (hit),
        .o_push (push)
    );

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LAT-2:0], start && !busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid       = r_vld[LAT-1];
    assign o_collided    = hit;
    assign o_stop_motion = hit;
    assign o_push_x      = push[0];
    assign o_push_y      = push[1];
    assign o_push_z      = push[2];

endmodule

[rtl/aabb_checker.sv]
// ----------------------------------------------------------------------------
// aabb_checker
// Port-level checks for the box collide and resolve unit, bound to the top.
// ----------------------------------------------------------------------------
module aabb_checker
    import aabb_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic                      o_collided,
    input logic signed [COORD_W-1:0] o_push_x,
    input logic signed [COORD_W-1:0] o_push_y,
    input logic signed [COORD_W-1:0] o_push_z,
    input logic                      o_stop_motion
);

    a_stop_eq_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stop_motion == o_collided))
        else $error("stop_motion differs from collided");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_collided) |-> (o_push_x == '0 && o_push_y == '0 && o_push_z == '0))
        else $error("push nonzero without collision");

    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_push_x != '0, o_push_y != '0, o_push_z != '0}) <= 1))
        else $error("push on more than one axis");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without request four cycles earlier");

endmodule

bind aabb_collide_resolve_unit aabb_checker u_aabb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_collided    (o_collided),
    .o_push_x      (o_push_x),
    .o_push_y      (o_push_y),
    .o_push_z      (o_push_z),
    .o_stop_motion (o_stop_motion)
);
